### hdl/atcw_pkg.sv
// atcw_pkg: shared constants, mode and register codes, and control structs
// for the terminal cell writer. No dependencies; imported by every module.
`default_nettype none

package atcw_pkg;

  localparam logic [1:0] MODE_BYTE  = 2'd0;
  localparam logic [1:0] MODE_FLUSH = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  localparam logic CFG_NORMAL  = 1'b0;
  localparam logic CFG_REVERSE = 1'b1;

  localparam logic [7:0] RESET_NORMAL_ATTR  = 8'h07;
  localparam logic [7:0] RESET_REVERSE_ATTR = 8'h70;

  localparam logic [7:0] ESC_BYTE    = 8'h1b;
  localparam logic [7:0] BLANK_CHAR  = 8'h20;
  localparam logic [7:0] CHAR_CR     = 8'h0d;
  localparam logic [7:0] CHAR_LF     = 8'h0a;
  localparam logic [7:0] CHAR_OPEN   = 8'h5b;
  localparam logic [7:0] CHAR_QUEST  = 8'h3f;
  localparam logic [7:0] CHAR_SEMI   = 8'h3b;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_CUP    = 8'h48;
  localparam logic [7:0] CHAR_EL     = 8'h4b;
  localparam logic [7:0] CHAR_SGR    = 8'h6d;
  localparam logic [7:0] CHAR_SET    = 8'h68;
  localparam logic [7:0] CHAR_RESET  = 8'h6c;

  localparam logic [7:0] SGR_NORMAL  = 8'd0;
  localparam logic [7:0] SGR_INVERSE = 8'd7;
  localparam logic [7:0] NUM_MAX     = 8'd255;

  localparam logic [15:0] BLANK_WORD = {RESET_NORMAL_ATTR, BLANK_CHAR};

  typedef struct packed {
    logic start;
    logic take;
  } ctrl_cmd_t;

  typedef struct packed {
    logic idle;
    logic done;
  } ctrl_stat_t;

endpackage

`default_nettype wire

### hdl/atcw_cell_store.sv
// atcw_cell_store: character cell memory, one write and one registered read
// port, with a blanking sweep after reset. Uses atcw_pkg.
`default_nettype none

module atcw_cell_store #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25,
  localparam int CELLS  = COLUMNS * ROWS,
  localparam int ADDR_W = $clog2(CELLS)
) (
  input  logic              clk,
  input  logic              rst,
  output logic              ready,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [15:0]       wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [15:0]       rd_data
);
  import atcw_pkg::*;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);

  logic [15:0]       mem [CELLS];
  logic              clearing;
  logic [ADDR_W-1:0] clr_addr;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [15:0]       mem_wdata;

  assign ready     = !clearing;
  assign mem_we    = clearing || wr_en;
  assign mem_waddr = clearing ? clr_addr : wr_addr;
  assign mem_wdata = clearing ? BLANK_WORD : wr_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == LAST_ADDR) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### hdl/atcw_ctrl.sv
// atcw_ctrl: escape parser, cursor and attribute state, and the sequencer
// that drives cell writes, line erase and cell reads. Uses atcw_pkg.
`default_nettype none

module atcw_ctrl #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25,
  localparam int CELLS  = COLUMNS * ROWS,
  localparam int ADDR_W = $clog2(CELLS),
  localparam int COL_W  = $clog2(COLUMNS + 1),
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  atcw_pkg::ctrl_cmd_t   cmd,
  output atcw_pkg::ctrl_stat_t  stat,
  input  logic [1:0]            mode,
  input  logic [7:0]            byte_in,
  input  logic [ADDR_W-1:0]     cell_index,
  input  logic [7:0]            normal_attribute,
  input  logic [7:0]            reverse_attribute,
  output logic                  wr_en,
  output logic [ADDR_W-1:0]     wr_addr,
  output logic [15:0]           wr_data,
  output logic                  rd_en,
  output logic [ADDR_W-1:0]     rd_addr,
  input  logic [15:0]           rd_data,
  output logic [15:0]           res_word,
  output logic                  res_show,
  output logic [COL_W-1:0]      res_col,
  output logic [ROW_W-1:0]      res_row
);
  import atcw_pkg::*;

  localparam logic [COL_W-1:0]  COL_END    = COL_W'(COLUMNS);
  localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(ROWS - 1);
  localparam logic [7:0]        LAST_COL_B = 8'(COLUMNS - 1);
  localparam logic [7:0]        LAST_ROW_B = 8'(ROWS - 1);
  localparam logic [ADDR_W:0]   CELL_LIMIT = (ADDR_W + 1)'(CELLS);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXEC   = 5'b00010,
    S_ERASE  = 5'b00100,
    S_RDWAIT = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  typedef enum logic [5:0] {
    PH_TEXT = 6'b000001,
    PH_ESC  = 6'b000010,
    PH_OPEN = 6'b000100,
    PH_NUM1 = 6'b001000,
    PH_NUM2 = 6'b010000,
    PH_PRIV = 6'b100000
  } phase_t;

  function automatic logic [7:0] accumulate(input logic [7:0] acc, input logic [3:0] dig);
    logic [11:0] v;
    v = 12'(acc) * 12'd10 + 12'(dig);
    return (v > 12'(NUM_MAX)) ? NUM_MAX : v[7:0];
  endfunction

  state_t            state, state_next;
  phase_t            phase, phase_next;
  logic [COL_W-1:0]  cur_col, cur_col_next;
  logic [ROW_W-1:0]  cur_row, cur_row_next;
  logic [7:0]        attr, attr_next;
  logic [7:0]        first_num, first_num_next;
  logic              first_present, first_present_next;
  logic [7:0]        second_num, second_num_next;
  logic [COL_W-1:0]  erase_col, erase_col_next;
  logic [15:0]       res_word_next;
  logic              res_show_next;

  logic [1:0]        mode_q;
  logic [7:0]        byte_q;
  logic [ADDR_W-1:0] idx_q;

  logic              is_digit;
  logic [7:0]        first_acc;
  logic [7:0]        second_acc;
  logic [7:0]        row_pick;
  logic [7:0]        col_pick;
  logic              put_req;
  logic              plain_req;
  logic              finish_req;
  logic [7:0]        wr_char;
  logic [COL_W-1:0]  wr_col;
  logic [ADDR_W-1:0] row_base;

  assign is_digit   = (byte_q >= CHAR_ZERO) && (byte_q <= CHAR_NINE);
  assign first_acc  = accumulate(first_num, byte_q[3:0]);
  assign second_acc = accumulate(second_num, byte_q[3:0]);

  always_comb begin
    row_pick = (first_present && first_num != 8'd0) ? first_num - 8'd1 : 8'd0;
    if (row_pick > LAST_ROW_B) begin
      row_pick = LAST_ROW_B;
    end
    col_pick = (second_num != 8'd0) ? second_num - 8'd1 : 8'd0;
    if (col_pick > LAST_COL_B) begin
      col_pick = LAST_COL_B;
    end
  end

  assign row_base = ADDR_W'(ADDR_W'(cur_row) * ADDR_W'(COLUMNS));
  assign wr_addr  = row_base + ADDR_W'(wr_col);
  assign wr_data  = {attr, wr_char};
  assign rd_addr  = idx_q;

  always_comb begin
    state_next         = state;
    phase_next         = phase;
    cur_col_next       = cur_col;
    cur_row_next       = cur_row;
    attr_next          = attr;
    first_num_next     = first_num;
    first_present_next = first_present;
    second_num_next    = second_num;
    erase_col_next     = erase_col;
    res_word_next      = res_word;
    res_show_next      = res_show;
    put_req            = 1'b0;
    plain_req          = 1'b0;
    finish_req         = 1'b0;
    wr_en              = 1'b0;
    wr_char            = byte_q;
    wr_col             = cur_col;
    rd_en              = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (cmd.start) begin
          res_word_next = 16'd0;
          res_show_next = 1'b0;
          state_next    = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_DONE;
        case (mode_q)
          MODE_BYTE: begin
            unique case (phase)
              PH_ESC: begin
                if (byte_q == CHAR_OPEN) begin
                  phase_next         = PH_OPEN;
                  first_num_next     = 8'd0;
                  first_present_next = 1'b0;
                  second_num_next    = 8'd0;
                end else begin
                  // lone escape lands as a cell, then the byte runs again as text
                  phase_next = PH_TEXT;
                  put_req    = 1'b1;
                  wr_char    = ESC_BYTE;
                  state_next = S_EXEC;
                end
              end
              PH_OPEN: begin
                if (byte_q == CHAR_QUEST) begin
                  phase_next = PH_PRIV;
                end else if (is_digit) begin
                  first_num_next     = first_acc;
                  first_present_next = 1'b1;
                  phase_next         = PH_NUM1;
                end else if (byte_q == CHAR_SEMI) begin
                  phase_next = PH_NUM2;
                end else begin
                  finish_req = 1'b1;
                end
              end
              PH_NUM1: begin
                if (is_digit) begin
                  first_num_next     = first_acc;
                  first_present_next = 1'b1;
                end else if (byte_q == CHAR_SEMI) begin
                  phase_next = PH_NUM2;
                end else begin
                  finish_req = 1'b1;
                end
              end
              PH_NUM2: begin
                if (is_digit) begin
                  second_num_next = second_acc;
                end else begin
                  finish_req = 1'b1;
                end
              end
              PH_PRIV: begin
                if (byte_q == CHAR_SET) begin
                  res_show_next = 1'b1;
                  phase_next    = PH_TEXT;
                end else if (byte_q == CHAR_RESET) begin
                  phase_next = PH_TEXT;
                end
              end
              default: begin
                plain_req = 1'b1;
              end
            endcase
          end
          MODE_FLUSH: begin
            res_show_next = 1'b1;
          end
          MODE_READ: begin
            if ({1'b0, idx_q} < CELL_LIMIT) begin
              rd_en      = 1'b1;
              state_next = S_RDWAIT;
            end
          end
          default: begin
          end
        endcase

        if (plain_req) begin
          if (byte_q == ESC_BYTE) begin
            phase_next = PH_ESC;
          end else if (byte_q == CHAR_CR) begin
            cur_col_next = '0;
          end else if (byte_q == CHAR_LF) begin
            cur_row_next = (cur_row < LAST_ROW) ? cur_row + ROW_W'(1) : LAST_ROW;
          end else begin
            put_req = 1'b1;
          end
        end

        if (finish_req) begin
          phase_next = PH_TEXT;
          if (byte_q == CHAR_CUP) begin
            cur_row_next = ROW_W'(row_pick);
            cur_col_next = COL_W'(col_pick);
          end else if (byte_q == CHAR_EL) begin
            erase_col_next = cur_col;
            state_next     = S_ERASE;
          end else if (byte_q == CHAR_SGR) begin
            if (first_num == SGR_INVERSE) begin
              attr_next = reverse_attribute;
            end else if (first_num == SGR_NORMAL) begin
              attr_next = normal_attribute;
            end
          end
        end

        if (put_req && cur_col < COL_END) begin
          wr_en        = 1'b1;
          cur_col_next = cur_col + COL_W'(1);
        end
      end
      S_ERASE: begin
        wr_col  = erase_col;
        wr_char = BLANK_CHAR;
        if (erase_col < COL_END) begin
          wr_en          = 1'b1;
          erase_col_next = erase_col + COL_W'(1);
        end else begin
          state_next = S_DONE;
        end
      end
      S_RDWAIT: begin
        res_word_next = rd_data;
        state_next    = S_DONE;
      end
      S_DONE: begin
        if (cmd.take) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      phase         <= PH_TEXT;
      cur_col       <= '0;
      cur_row       <= '0;
      attr          <= RESET_NORMAL_ATTR;
      first_num     <= 8'd0;
      first_present <= 1'b0;
      second_num    <= 8'd0;
      erase_col     <= '0;
    end else begin
      state         <= state_next;
      phase         <= phase_next;
      cur_col       <= cur_col_next;
      cur_row       <= cur_row_next;
      attr          <= attr_next;
      first_num     <= first_num_next;
      first_present <= first_present_next;
      second_num    <= second_num_next;
      erase_col     <= erase_col_next;
    end
  end

  always_ff @(posedge clk) begin
    res_word <= res_word_next;
    res_show <= res_show_next;
    if (cmd.start) begin
      mode_q <= mode;
      byte_q <= byte_in;
      idx_q  <= cell_index;
    end
  end

  assign stat.idle = (state == S_IDLE);
  assign stat.done = (state == S_DONE);
  assign res_col   = cur_col;
  assign res_row   = cur_row;

  a_quiet_outside_work: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_DONE || state == S_RDWAIT) |-> !wr_en)
    else $error("cell write outside a working state");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    cur_col <= COL_END)
    else $error("cursor column beyond end of line");

  a_write_in_line: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (wr_col < COL_END))
    else $error("cell write past the last column");

  a_read_wait: assert property (@(posedge clk) disable iff (rst)
    rd_en |=> (state == S_RDWAIT))
    else $error("read issued without waiting for data");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && !cmd.take) |=> (state == S_DONE && $stable(res_word)))
    else $error("finished result lost before hand-off");

endmodule

`default_nettype wire

### hdl/ansi_text_terminal_cell_writer_unit.sv
// ansi_text_terminal_cell_writer_unit: top level with configuration registers,
// result register and handshakes. Uses atcw_pkg, atcw_cell_store and atcw_ctrl.
//
//   channel  | signals                                        | direction
//   ---------+------------------------------------------------+----------
//   in       | in_valid, in_ready, mode, byte_in, cell_index  | sink
//   out      | out_valid, out_ready, cell_word, cursor_col,   | source
//            | cursor_row, show_request, shown_col            |
//   cfg      | cfg_write, cfg_index, cfg_data                 | sink
//
// a stream byte or end of write passes through S_EXEC and S_DONE into the
// output register, a byte that ends with an escape cell and a second cell runs
// S_EXEC twice, a cell read adds S_RDWAIT for the registered memory read, and
// an erase to end of line adds S_ERASE, which blanks each cell to the line end.
// after reset a blanking sweep writes every cell with
// in_ready low; configuration writes are taken throughout.
// a new beat is accepted while the previous result waits in the output register.
`default_nettype none

module ansi_text_terminal_cell_writer_unit #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25,
  localparam int CELLS  = COLUMNS * ROWS,
  localparam int IDX_W  = $clog2(CELLS),
  localparam int COL_W  = $clog2(COLUMNS + 1),
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       mode,
  input  logic [7:0]       byte_in,
  input  logic [IDX_W-1:0] cell_index,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [15:0]      cell_word,
  output logic [COL_W-1:0] cursor_col,
  output logic [ROW_W-1:0] cursor_row,
  output logic             show_request,
  output logic [COL_W-1:0] shown_col,
  input  logic             cfg_write,
  input  logic             cfg_index,
  input  logic [7:0]       cfg_data
);
  import atcw_pkg::*;

  localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);

  logic [7:0]       normal_attribute;
  logic [7:0]       reverse_attribute;
  ctrl_cmd_t        cmd;
  ctrl_stat_t       stat;
  logic             store_ready;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [15:0]      wr_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [15:0]      rd_data;
  logic [15:0]      res_word;
  logic             res_show;
  logic [COL_W-1:0] res_col;
  logic [ROW_W-1:0] res_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      normal_attribute  <= RESET_NORMAL_ATTR;
      reverse_attribute <= RESET_REVERSE_ATTR;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_NORMAL:  normal_attribute  <= cfg_data;
        CFG_REVERSE: reverse_attribute <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign in_ready  = stat.idle && store_ready;
  assign cmd.start = in_valid && in_ready;
  assign cmd.take  = stat.done && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      cell_word    <= res_word;
      cursor_col   <= res_col;
      cursor_row   <= res_row;
      show_request <= res_show;
      shown_col    <= (res_col > LAST_COL) ? LAST_COL : res_col;
    end
  end

  atcw_cell_store #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .ready   (store_ready),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  atcw_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_ctrl (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .mode              (mode),
    .byte_in           (byte_in),
    .cell_index        (cell_index),
    .normal_attribute  (normal_attribute),
    .reverse_attribute (reverse_attribute),
    .wr_en             (wr_en),
    .wr_addr           (wr_addr),
    .wr_data           (wr_data),
    .rd_en             (rd_en),
    .rd_addr           (rd_addr),
    .rd_data           (rd_data),
    .res_word          (res_word),
    .res_show          (res_show),
    .res_col           (res_col),
    .res_row           (res_row)
  );

endmodule

`default_nettype wire

### bench/tb.sv
// tb: self-checking bench for the terminal cell writer, a byte stream into an 80x25 cell store.
// Holds its own model of cursor, attribute, parser and cells and checks every result beat.
// Depends on atcw_pkg and ansi_text_terminal_cell_writer_unit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import atcw_pkg::*;

  localparam int COLS = 80;
  localparam int ROWS = 25;
  localparam int CELLS = COLS * ROWS;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_AT = 700;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_BEATS = 365;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  typedef enum logic [2:0] {
    PH_TEXT, PH_ESC, PH_OPEN, PH_NUM1, PH_NUM2, PH_PRIV
  } parse_phase_t;

  typedef struct packed {
    logic [1:0]  m;
    logic [7:0]  b;
    logic [10:0] ix;
  } beat_t;

  typedef struct packed {
    logic [15:0] word;
    logic [6:0]  col;
    logic [4:0]  row;
    logic        show;
    logic [6:0]  vis_col;
  } view_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  mode = MODE_BYTE;
  logic [7:0]  byte_in = 8'h00;
  logic [10:0] cell_index = 11'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] cell_word;
  logic [6:0]  cursor_col;
  logic [4:0]  cursor_row;
  logic        show_request;
  logic [6:0]  shown_col;
  logic        cfg_write = 1'b0;
  logic        cfg_index = CFG_NORMAL;
  logic [7:0]  cfg_data = 8'h00;

  ansi_text_terminal_cell_writer_unit #(
    .COLUMNS(COLS),
    .ROWS(ROWS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .mode(mode),
    .byte_in(byte_in),
    .cell_index(cell_index),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cell_word(cell_word),
    .cursor_col(cursor_col),
    .cursor_row(cursor_row),
    .show_request(show_request),
    .shown_col(shown_col),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // model of the terminal state
  logic [15:0]  screen [CELLS];
  logic [6:0]   cur_c;
  logic [4:0]   cur_r;
  logic [7:0]   cur_attr;
  parse_phase_t phase;
  logic [7:0]   num_a;
  logic [7:0]   num_b;
  logic         num_a_seen;
  logic [7:0]   attr_normal;
  logic [7:0]   attr_reverse;

  beat_t       outgoing_beats [$];
  view_t       expected_views [$];
  int unsigned beats_queued = 0;
  int unsigned beats_in = 0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  bit          quiet_run = 1'b0;
  int unsigned faults = 0;
  int unsigned cycle_count = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    return quiet_run ? 0 : $urandom_range(0, 6);
  endfunction

  function automatic logic [7:0] add_digit(logic [7:0] acc, logic [7:0] ch);
    int unsigned v;
    v = int'(acc) * 10 + int'(ch - CHAR_ZERO);
    return (v > 255) ? NUM_MAX : v[7:0];
  endfunction

  task automatic put_cell(input logic [7:0] ch);
    if (cur_c < COLS) begin
      screen[cur_r * COLS + cur_c] = {cur_attr, ch};
      cur_c = cur_c + 7'd1;
    end
  endtask

  task automatic plain_text(input logic [7:0] b);
    if (b == ESC_BYTE) begin
      phase = PH_ESC;
    end else if (b == CHAR_CR) begin
      cur_c = 7'd0;
    end else if (b == CHAR_LF) begin
      if (cur_r < ROWS - 1) cur_r = cur_r + 5'd1;
    end else begin
      put_cell(b);
    end
  endtask

  task automatic close_sequence(input logic [7:0] b);
    int r;
    int k;
    phase = PH_TEXT;
    if (b == CHAR_CUP) begin
      r = (num_a_seen && num_a > 0) ? int'(num_a) - 1 : 0;
      k = (num_b > 0) ? int'(num_b) - 1 : 0;
      cur_r = 5'((r > ROWS - 1) ? ROWS - 1 : r);
      cur_c = 7'((k > COLS - 1) ? COLS - 1 : k);
    end else if (b == CHAR_EL) begin
      for (int c = cur_c; c < COLS; c++) screen[cur_r * COLS + c] = {cur_attr, BLANK_CHAR};
    end else if (b == CHAR_SGR) begin
      if (num_a == SGR_INVERSE) cur_attr = attr_reverse;
      else if (num_a == SGR_NORMAL) cur_attr = attr_normal;
    end
  endtask

  task automatic terminal_step(input beat_t t, output view_t v);
    logic [7:0]  b;
    logic        dig;
    logic [15:0] word;
    logic        show;
    b = t.b;
    dig = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    word = 16'h0000;
    show = 1'b0;
    if (t.m == MODE_BYTE) begin
      case (phase)
        PH_ESC: begin
          if (b == CHAR_OPEN) begin
            phase = PH_OPEN;
            num_a = 8'd0;
            num_a_seen = 1'b0;
            num_b = 8'd0;
          end else begin
            phase = PH_TEXT;
            put_cell(ESC_BYTE);
            plain_text(b);
          end
        end
        PH_OPEN: begin
          if (b == CHAR_QUEST) begin
            phase = PH_PRIV;
          end else if (dig) begin
            num_a = add_digit(num_a, b);
            num_a_seen = 1'b1;
            phase = PH_NUM1;
          end else if (b == CHAR_SEMI) begin
            phase = PH_NUM2;
          end else begin
            close_sequence(b);
          end
        end
        PH_NUM1: begin
          if (dig) begin
            num_a = add_digit(num_a, b);
            num_a_seen = 1'b1;
          end else if (b == CHAR_SEMI) begin
            phase = PH_NUM2;
          end else begin
            close_sequence(b);
          end
        end
        PH_NUM2: begin
          if (dig) num_b = add_digit(num_b, b);
          else close_sequence(b);
        end
        PH_PRIV: begin
          if (b == CHAR_SET) begin
            show = 1'b1;
            phase = PH_TEXT;
          end else if (b == CHAR_RESET) begin
            phase = PH_TEXT;
          end
        end
        default: begin
          phase = PH_TEXT;
          plain_text(b);
        end
      endcase
    end else if (t.m == MODE_FLUSH) begin
      show = 1'b1;
    end else if (t.m == MODE_READ) begin
      if (t.ix < CELLS) word = screen[t.ix];
    end
    v.word = word;
    v.col = cur_c;
    v.row = cur_r;
    v.show = show;
    v.vis_col = (cur_c > COLS - 1) ? 7'(COLS - 1) : cur_c;
  endtask

  // stimulus builders
  task automatic push_beat(input logic [1:0] m, input logic [7:0] b, input logic [10:0] ix);
    beat_t t;
    t.m = m;
    t.b = b;
    t.ix = ix;
    outgoing_beats.push_back(t);
    beats_queued++;
  endtask

  task automatic push_char(input logic [7:0] b);
    push_beat(MODE_BYTE, b, 11'($urandom_range(0, 2047)));
  endtask

  task automatic push_flush();
    push_beat(MODE_FLUSH, 8'($urandom), 11'($urandom_range(0, 2047)));
  endtask

  task automatic push_read(input int ix);
    push_beat(MODE_READ, 8'($urandom), 11'(ix));
  endtask

  // escape bytes, now and then cut by an end of write
  task automatic push_seq(input logic [7:0] b);
    if ($urandom_range(0, 24) == 0) push_flush();
    push_char(b);
  endtask

  task automatic push_csi();
    push_seq(ESC_BYTE);
    push_seq(CHAR_OPEN);
  endtask

  task automatic push_decimal(input int n);
    string s;
    s = $sformatf("%0d", n);
    for (int i = 0; i < s.len(); i++) push_seq(s[i]);
  endtask

  function automatic int pick_number(int lim);
    case ($urandom_range(0, 7))
      0: return 0;
      1: return $urandom_range(lim, 999);
      default: return $urandom_range(1, lim + 2);
    endcase
  endfunction

  task automatic queue_random_burst();
    int kind;
    int n;
    int r;
    int c;
    int start;
    kind = $urandom_range(0, 99);
    if (kind < 24) begin
      n = $urandom_range(1, 12);
      repeat (n) push_char(8'($urandom_range(32, 126)));
    end else if (kind < 32) begin
      case ($urandom_range(0, 2))
        0: push_char(CHAR_CR);
        1: push_char(CHAR_LF);
        default: begin
          push_char(CHAR_CR);
          push_char(CHAR_LF);
        end
      endcase
    end else if (kind < 46) begin
      push_csi();
      if ($urandom_range(0, 4) != 0) push_decimal(pick_number(ROWS));
      if ($urandom_range(0, 4) != 0) begin
        push_seq(CHAR_SEMI);
        if ($urandom_range(0, 4) != 0) push_decimal(pick_number(COLS));
      end
      push_seq(CHAR_CUP);
    end else if (kind < 54) begin
      push_csi();
      if ($urandom_range(0, 3) == 0) push_decimal($urandom_range(0, 2));
      push_seq(CHAR_EL);
    end else if (kind < 64) begin
      push_csi();
      case ($urandom_range(0, 3))
        0: push_decimal(SGR_NORMAL);
        1: push_decimal(SGR_INVERSE);
        2: push_decimal($urandom_range(0, 300));
        default: ;
      endcase
      push_seq(CHAR_SGR);
    end else if (kind < 69) begin
      push_csi();
      push_seq(CHAR_QUEST);
      n = $urandom_range(0, 4);
      repeat (n) push_seq(8'($urandom_range(32, 103)));
      push_seq($urandom_range(0, 1) ? CHAR_SET : CHAR_RESET);
    end else if (kind < 74) begin
      push_seq(ESC_BYTE);
      push_seq(8'($urandom));
    end else if (kind < 79) begin
      push_csi();
      if ($urandom_range(0, 1) != 0) push_decimal($urandom_range(0, 400));
      if ($urandom_range(0, 2) == 0) push_seq(CHAR_SEMI);
      push_seq(8'($urandom));
    end else if (kind < 84) begin
      push_flush();
    end else if (kind < 90) begin
      start = $urandom_range(0, 2047);
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) push_read((start + i) % 2048);
    end else if (kind < 97) begin
      // place the cursor, write or erase, then read the same cells back
      r = $urandom_range(0, ROWS - 1);
      c = $urandom_range(0, COLS - 1);
      n = $urandom_range(1, 8);
      push_csi();
      push_decimal(r + 1);
      push_seq(CHAR_SEMI);
      push_decimal(c + 1);
      push_seq(CHAR_CUP);
      if ($urandom_range(0, 2) == 0) begin
        push_csi();
        push_seq(CHAR_EL);
      end else begin
        repeat (n) push_char(8'($urandom));
      end
      for (int i = 0; i < n; i++) push_read(r * COLS + c + i);
    end else if (kind < 99) begin
      push_beat(MODE_SPARE, 8'($urandom), 11'($urandom_range(0, 2047)));
    end else begin
      push_char(8'($urandom));
    end
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_NORMAL) attr_normal = val;
    else attr_reverse = val;
  endtask

  task automatic settle();
    while (outgoing_beats.size() != 0 || in_valid || expected_views.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // sender
  always @(posedge clk) begin
    int unsigned gap;
    view_t       v;
    beat_t       took;
    beat_t       nxt;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      gap = send_gap;
      if (in_valid && in_ready) begin
        took.m = mode;
        took.b = byte_in;
        took.ix = cell_index;
        terminal_step(took, v);
        expected_views.push_back(v);
        beats_in <= beats_in + 1;
        gap = pick_gap();
      end
      if (!in_valid || in_ready) begin
        if (gap == 0 && outgoing_beats.size() != 0) begin
          nxt = outgoing_beats.pop_front();
          mode <= nxt.m;
          byte_in <= nxt.b;
          cell_index <= nxt.ix;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
          if (gap != 0) gap = gap - 1;
        end
      end
      send_gap <= gap;
    end
  end

  // long receiver hold-off so the block backs up
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && beats_in >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    int unsigned gap;
    view_t       got;
    view_t       want;
    if (rst) begin
      out_ready <= 1'b0;
      recv_gap <= 0;
    end else begin
      gap = recv_gap;
      if (out_valid && out_ready) begin
        got.word = cell_word;
        got.col = cursor_col;
        got.row = cursor_row;
        got.show = show_request;
        got.vis_col = shown_col;
        if (expected_views.size() == 0) begin
          if (faults < 10)
            $display("unexpected result beat: word %h col %0d row %0d show %0d shown %0d",
                     got.word, got.col, got.row, got.show, got.vis_col);
          faults++;
        end else begin
          want = expected_views.pop_front();
          if (got.word !== want.word || got.col !== want.col || got.row !== want.row ||
              got.show !== want.show || got.vis_col !== want.vis_col) begin
            if (faults < 10)
              $display("mismatch (exp/got): word %h/%h col %0d/%0d row %0d/%0d show %0d/%0d shown %0d/%0d",
                       want.word, got.word, want.col, got.col, want.row, got.row,
                       want.show, got.show, want.vis_col, got.vis_col);
            faults++;
          end
        end
        gap = pick_gap();
      end else if (gap != 0) begin
        gap = gap - 1;
      end
      recv_gap <= gap;
      out_ready <= (gap == 0) && (hold_left == 0);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned mark;
    for (int i = 0; i < CELLS; i++) screen[i] = {RESET_NORMAL_ATTR, BLANK_CHAR};
    cur_c = 7'd0;
    cur_r = 5'd0;
    attr_normal = RESET_NORMAL_ATTR;
    attr_reverse = RESET_REVERSE_ATTR;
    cur_attr = RESET_NORMAL_ATTR;
    phase = PH_TEXT;
    num_a = 8'd0;
    num_b = 8'd0;
    num_a_seen = 1'b0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    // blanking sweep after reset
    do @(posedge clk); while (!in_ready);

    // private sequence cut by an end of write, ending in h
    push_char(ESC_BYTE);
    push_char(CHAR_OPEN);
    push_char(CHAR_QUEST);
    push_flush();
    push_char(8'(CHAR_ZERO + 2));
    push_char(CHAR_SET);
    // lone escape written as a cell
    push_char(ESC_BYTE);
    push_char("x");
    // reverse attribute, then a top-value byte
    push_char(ESC_BYTE);
    push_char(CHAR_OPEN);
    push_char(8'(CHAR_ZERO + SGR_INVERSE));
    push_char(CHAR_SGR);
    push_char(8'hff);
    // saturated row, missing column, then line feed on the last row
    push_char(ESC_BYTE);
    push_char(CHAR_OPEN);
    push_char(8'(CHAR_ZERO + 3));
    push_char(CHAR_ZERO);
    push_char(CHAR_ZERO);
    push_char(CHAR_CUP);
    push_char(CHAR_LF);
    push_char(8'h00);
    push_read(2);
    push_read((ROWS - 1) * COLS);
    push_read(2047);
    push_beat(MODE_SPARE, 8'h00, 11'd0);
    settle();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          write_reg(CFG_NORMAL, 8'h00);
          write_reg(CFG_REVERSE, 8'hff);
        end
        1: begin
          write_reg(CFG_NORMAL, 8'hff);
          write_reg(CFG_REVERSE, 8'h00);
        end
        2: begin
          write_reg(CFG_NORMAL, 8'($urandom));
          write_reg(CFG_REVERSE, 8'($urandom));
        end
        default: begin
          write_reg(CFG_NORMAL, RESET_NORMAL_ATTR);
          write_reg(CFG_REVERSE, RESET_REVERSE_ATTR);
        end
      endcase
      quiet_run = (p == 1);
      mark = beats_queued;
      while (beats_queued - mark < PHASE_BEATS) queue_random_burst();
      settle();
    end

    faults += expected_views.size();
    if (faults == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
